/* rtl/idq_pkg.sv */
`default_nettype none
package idq_pkg;

  localparam logic [2:0] REQ_INS_HEAD = 3'd0;
  localparam logic [2:0] REQ_INS_TAIL = 3'd1;
  localparam logic [2:0] REQ_REM_HEAD = 3'd2;
  localparam logic [2:0] REQ_REM_TAIL = 3'd3;
  localparam logic [2:0] REQ_READ     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic accept;
    logic commit;
  } idq_ctl_t;

  typedef struct packed {
    logic res_hold;
  } idq_sts_t;

endpackage
`default_nettype wire

/* rtl/indexed_double_ended_queue_unit.sv */
`default_nettype none
// Double-ended queue of element words in a ring store with indexed read. Each
// accepted request yields one result carrying the element read (reads only),
// the count after the request and a status. A request reads the store at
// acceptance into a register; the pointers, count and store write are
// updated at commit in the execute state, and no new request is taken
// until then. A finished result sits in an output register and the next
// request is taken while it waits; a request stays in its update state
// only while that register is still full and stalled. The store needs
// no clearing after reset; reading a slot never written returns junk.
module indexed_double_ended_queue_unit #(
  parameter int DEPTH      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_element,
  input  wire logic [7:0]  in_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_element,
  output logic [8:0]       out_count,
  output logic [1:0]       out_status
);
  import idq_pkg::*;

  idq_ctl_t ctl;
  idq_sts_t sts;

  idq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  idq_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_element       (in_element),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_element (out_read_element),
    .out_count        (out_count),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

/* rtl/idq_ctrl.sv */
`default_nettype none
module idq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output idq_pkg::idq_ctl_t      ctl,
  input  wire idq_pkg::idq_sts_t sts
);
  import idq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign ctl.accept = in_valid && (state_r == S_IDLE);
  assign ctl.commit = (state_r == S_EXEC) && !sts.res_hold;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (ctl.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

/* rtl/idq_dp.sv */
`default_nettype none
module idq_dp #(
  parameter int DEPTH      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire idq_pkg::idq_ctl_t ctl,
  output idq_pkg::idq_sts_t      sts,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [31:0]       in_element,
  input  wire logic [7:0]        in_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_read_element,
  output logic [8:0]             out_count,
  output logic [1:0]             out_status
);
  import idq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
  localparam int XW = (CW > 8) ? CW : 8;

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rd_q;

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [2:0]    req_r;
  logic [SW-1:0] elem_r;
  logic [7:0]    idx_r;
  logic [PW-1:0] addr_r;

  logic          out_valid_r;
  logic [31:0]   res_elem_r;
  logic [8:0]    res_count_r;
  logic [1:0]    res_status_r;

  logic [PW-1:0] logical;
  logic [PW:0]   sum;
  logic [PW-1:0] slot;
  logic [PW-1:0] head_dec, head_inc;
  logic [PW-1:0] addr_nxt;
  logic          full, empty, in_range, wr_en;
  logic [31:0]   res_elem_nxt;
  logic [1:0]    res_status_nxt;

  assign sts.res_hold = out_valid_r && out_stall;

  // ring slot of a logical position, one wrap at most
  assign logical  = (in_req_type == REQ_INS_TAIL) ? PW'(count_r) : PW'(in_index);
  assign sum      = {1'b0, head_r} + {1'b0, logical};
  assign slot     = (sum >= (PW+1)'(DEPTH)) ? PW'(sum - (PW+1)'(DEPTH)) : sum[PW-1:0];
  assign head_dec = (head_r == '0) ? PW'(DEPTH - 1) : head_r - PW'(1);
  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
  assign addr_nxt = (in_req_type == REQ_INS_HEAD) ? head_dec : slot;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_range = XW'(idx_r) < XW'(count_r);
  assign wr_en    = ((req_r == REQ_INS_HEAD) || (req_r == REQ_INS_TAIL)) && !full;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    res_elem_nxt   = '0;
    res_status_nxt = ST_OK;
    case (req_r)
      REQ_INS_HEAD: begin
        if (full) res_status_nxt = ST_FULL;
        else begin
          head_nxt  = addr_r;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_INS_TAIL: begin
        if (full) res_status_nxt = ST_FULL;
        else      count_nxt = count_r + CW'(1);
      end
      REQ_REM_HEAD: begin
        if (empty) res_status_nxt = ST_EMPTY;
        else begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_REM_TAIL: begin
        if (empty) res_status_nxt = ST_EMPTY;
        else       count_nxt = count_r - CW'(1);
      end
      REQ_READ: begin
        if (in_range) res_elem_nxt = 32'(rd_q);
        else          res_status_nxt = ST_RANGE;
      end
      default: ;
    endcase
  end

  // store read happens at acceptance, write at commit
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rd_q   <= mem[addr_nxt];
      req_r  <= in_req_type;
      elem_r <= in_element[SW-1:0];
      idx_r  <= in_index;
      addr_r <= addr_nxt;
    end
    if (ctl.commit && wr_en) mem[addr_r] <= elem_r;
    if (ctl.commit) begin
      res_elem_r   <= res_elem_nxt;
      res_count_r  <= 9'(count_nxt);
      res_status_r <= res_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (ctl.commit)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_element = res_elem_r;
  assign out_count        = res_count_r;
  assign out_status       = res_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("count above depth");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= PW'(DEPTH - 1)) else $error("head outside ring");
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r) else $error("result not presented");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.commit |=> $stable(count_r)) else $error("count moved without commit");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !(out_valid_r && out_stall)) else $error("stalled result lost");
`endif

endmodule
`default_nettype wire
